FILE: design/can_maf_pkg.sv
// Shared types, codes and helpers for the CAN mailbox acceptance filter.
`timescale 1ns / 1ps

package can_maf_pkg;

  // Default geometry
  localparam int MAILBOX_COUNT_DEF = 16;
  localparam int CHANNEL_COUNT_DEF = 2;

  // Identifier forms
  localparam logic [29:0] ID29_MASK = 30'h1fffffff;
  localparam logic [29:0] EXT_BIT   = 30'h20000000;
  localparam logic [29:0] ID11_MASK = 30'h000007ff;
  localparam logic [3:0]  DLC_MAX   = 4'd8;

  typedef enum logic [1:0] {
    OP_CONFIG = 2'd0,
    OP_FRAME  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic        channel;
    logic [3:0]  mailbox;
    logic        extended;
    logic [28:0] ident;
    logic [28:0] id_mask;
    logic        irq_enable;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  found_mailbox;
    logic [63:0] out_payload;
    logic [29:0] out_ident;
    logic [3:0]  out_length;
    logic [15:0] pending_mask;
    logic        irq_raise;
  } out_item_t;

  // One acceptance filter entry
  typedef struct packed {
    logic [29:0] id;
    logic [29:0] mask;
    logic        ien;
  } filt_t;

  // One captured frame
  typedef struct packed {
    logic [63:0] payload;
    logic [29:0] ident;
    logic [3:0]  length;
  } data_t;

  // Normalize a received identifier: bit 29 marks extended
  function automatic logic [29:0] norm_id(input logic ext, input logic [28:0] ident);
    logic [29:0] wide;
    wide = {1'b0, ident};
    return ext ? ((wide & ID29_MASK) | EXT_BIT) : (wide & ID11_MASK);
  endfunction

  // Build the stored filter entry from a configure item
  function automatic filt_t cfg_entry(input in_item_t item);
    filt_t       ent;
    logic [29:0] id_w;
    logic [29:0] msk_w;
    id_w  = {1'b0, item.ident};
    msk_w = {1'b0, item.id_mask};
    if (item.extended) begin
      ent.mask = msk_w | EXT_BIT;
      ent.id   = (id_w & msk_w) | EXT_BIT;
    end else begin
      ent.mask = msk_w & ID11_MASK;
      ent.id   = id_w & msk_w & ID11_MASK;
    end
    ent.ien = item.irq_enable;
    return ent;
  endfunction

endpackage

FILE: design/can_maf_ram.sv
// Single-port-write, registered-read memory used for filter and frame storage.
`timescale 1ns / 1ps

module can_maf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule

FILE: design/can_maf_cmp.sv
// Shared acceptance compare unit: tests one filter entry against an identifier.
`timescale 1ns / 1ps

module can_maf_cmp (
  input  logic                entry_vld,
  input  can_maf_pkg::filt_t  entry,
  input  logic [29:0]         rid,
  output logic                hit,
  output logic                ien
);

  logic [29:0] mask_g;
  logic [29:0] id_g;

  // An entry never configured reads as zero mask and zero id
  assign mask_g = entry_vld ? entry.mask : '0;
  assign id_g   = entry_vld ? entry.id   : '0;

  assign hit = ((rid & mask_g) == id_g);
  assign ien = entry_vld & entry.ien;

endmodule

FILE: design/can_mailbox_acceptance_filter_core.sv
// Top level: sequencer, valid and pending bits, and storage for the mailbox filter.
`timescale 1ns / 1ps

// CAN mailbox acceptance filter. One item is taken when start is high and busy is low;
// exactly one result follows, shown on out_item for one cycle with out_valid high, and the
// receiver must take it then. Configure and clear end in S_CFG and S_CLR; a read passes
// through S_RD and S_RDOUT around one registered memory read. A received frame walks the
// channel's mailboxes in index order through one shared compare unit, one mailbox per
// cycle behind a registered memory read, then writes the capture in S_CAPT on a match.
// The result appears in the same cycle that busy drops. Reset clears valid and pending
// flip-flops at once; no clearing pass is needed.
module can_mailbox_acceptance_filter_core #(
  parameter int MAILBOX_COUNT = can_maf_pkg::MAILBOX_COUNT_DEF,
  parameter int CHANNEL_COUNT = can_maf_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  can_maf_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output can_maf_pkg::out_item_t out_item
);

  localparam int SLOTS = MAILBOX_COUNT * CHANNEL_COUNT;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW    = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
  localparam logic [MW-1:0] LAST_MB = MW'(MAILBOX_COUNT - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CFG   = 7'b0000010,
    S_CLR   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_RDOUT = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_CAPT  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  can_maf_pkg::in_item_t   item_r;
  logic [29:0]             rid_r;
  logic [MW-1:0]           idx_r, idx_nxt;
  logic                    iss_done_r, iss_done_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [MW-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic [MW-1:0]           hit_idx_r, hit_idx_nxt;
  logic                    hit_ien_r, hit_ien_nxt;
  logic [SLOTS-1:0]        filt_vld_r, filt_vld_nxt;
  logic [SLOTS-1:0]        full_r, full_nxt;
  logic [CHANNEL_COUNT-1:0][MAILBOX_COUNT-1:0] pend_r, pend_nxt;
  logic                    out_valid_r;
  can_maf_pkg::out_item_t  out_item_r;
  can_maf_pkg::out_item_t  res;
  logic                    emit;

  logic                    ch_ok;
  logic                    mb_ok;
  logic                    ch_sel;
  logic [MW-1:0]           mb_idx;
  logic [AW-1:0]           req_slot;
  logic [AW-1:0]           cmp_slot;
  logic [AW-1:0]           hit_slot;
  logic [AW-1:0]           ent_slot;
  logic [AW-1:0]           filt_raddr;
  logic                    filt_we;
  logic                    data_we;
  can_maf_pkg::filt_t      filt_rd;
  can_maf_pkg::data_t      data_rd;
  can_maf_pkg::data_t      data_wr;
  logic                    cmp_hit;
  logic                    cmp_ien;

  function automatic logic [AW-1:0] slot_of(input logic ch, input logic [MW-1:0] k);
    return AW'(32'(ch) * 32'(MAILBOX_COUNT) + 32'(k));
  endfunction

  // Decode the held item
  assign ch_ok    = (32'(item_r.channel) < 32'(CHANNEL_COUNT));
  assign mb_ok    = (32'(item_r.mailbox) < 32'(MAILBOX_COUNT));
  assign ch_sel   = ch_ok & item_r.channel;
  assign mb_idx   = item_r.mailbox[MW-1:0];
  assign req_slot = slot_of(ch_sel, mb_idx);
  assign cmp_slot = slot_of(ch_sel, cmp_idx_r);
  assign hit_slot = slot_of(ch_sel, hit_idx_r);
  assign ent_slot = (state_r == S_RDOUT) ? req_slot : cmp_slot;

  // Captured frame contents
  assign data_wr.payload = item_r.payload;
  assign data_wr.ident   = rid_r;
  assign data_wr.length  = (item_r.length_code > can_maf_pkg::DLC_MAX) ?
                           can_maf_pkg::DLC_MAX : item_r.length_code;

  can_maf_ram #(
    .WIDTH ($bits(can_maf_pkg::filt_t)),
    .DEPTH (SLOTS)
  ) u_filt_ram (
    .clk       (clk),
    .we        (filt_we),
    .waddr     (req_slot),
    .wdata     (can_maf_pkg::cfg_entry(item_r)),
    .raddr     (filt_raddr),
    .rd_data_r (filt_rd)
  );

  can_maf_ram #(
    .WIDTH ($bits(can_maf_pkg::data_t)),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk       (clk),
    .we        (data_we),
    .waddr     (hit_slot),
    .wdata     (data_wr),
    .raddr     (req_slot),
    .rd_data_r (data_rd)
  );

  can_maf_cmp u_cmp (
    .entry_vld (filt_vld_r[ent_slot]),
    .entry     (filt_rd),
    .rid       (rid_r),
    .hit       (cmp_hit),
    .ien       (cmp_ien)
  );

  // Sequence one item
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    iss_done_nxt = iss_done_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    hit_idx_nxt  = hit_idx_r;
    hit_ien_nxt  = hit_ien_r;
    filt_vld_nxt = filt_vld_r;
    full_nxt     = full_r;
    pend_nxt     = pend_r;
    filt_we      = 1'b0;
    data_we      = 1'b0;
    filt_raddr   = req_slot;
    emit         = 1'b0;
    res          = '0;
    res.status   = can_maf_pkg::ST_DONE;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
          unique case (in_item.op)
            can_maf_pkg::OP_CONFIG: state_nxt = S_CFG;
            can_maf_pkg::OP_FRAME:  state_nxt = S_SCAN;
            can_maf_pkg::OP_READ:   state_nxt = S_RD;
            can_maf_pkg::OP_CLEAR:  state_nxt = S_CLR;
            default:                state_nxt = S_IDLE;
          endcase
        end
      end

      S_CFG: begin
        // Store the filter and drop the mailbox's pending bit
        if (ch_ok && mb_ok) begin
          filt_we                  = 1'b1;
          filt_vld_nxt[req_slot]   = 1'b1;
          pend_nxt[ch_sel][mb_idx] = 1'b0;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_CLR: begin
        // Empty every mailbox of the channel
        if (ch_ok) begin
          for (int s = 0; s < SLOTS; s++) begin
            if ((s / MAILBOX_COUNT) == int'(ch_sel)) begin
              filt_vld_nxt[s] = 1'b0;
              full_nxt[s]     = 1'b0;
            end
          end
          pend_nxt[ch_sel] = '0;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_RD: begin
        state_nxt = S_RDOUT;
      end

      S_RDOUT: begin
        // Return and empty the mailbox
        res.found_mailbox = item_r.mailbox;
        if (ch_ok && mb_ok && full_r[req_slot]) begin
          res.out_payload = data_rd.payload;
          res.out_ident   = data_rd.ident;
          res.out_length  = data_rd.length;
          if (cmp_ien) begin
            pend_nxt[ch_sel][mb_idx] = 1'b0;
          end
          full_nxt[req_slot] = 1'b0;
        end else begin
          res.status = can_maf_pkg::ST_EMPTY;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        if (!ch_ok) begin
          res.status = can_maf_pkg::ST_NOMATCH;
          emit       = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          // Issue the next filter read
          filt_raddr = slot_of(ch_sel, idx_r);
          if (!iss_done_r) begin
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = idx_r;
            if (idx_r == LAST_MB) begin
              iss_done_nxt = 1'b1;
            end else begin
              idx_nxt = idx_r + MW'(1);
            end
          end
          // Compare the entry read last cycle
          if (cmp_vld_r) begin
            if (cmp_hit) begin
              hit_idx_nxt = cmp_idx_r;
              hit_ien_nxt = cmp_ien;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_CAPT;
            end else if (cmp_idx_r == LAST_MB) begin
              res.status = can_maf_pkg::ST_NOMATCH;
              emit       = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end

      S_CAPT: begin
        // Write the frame into the matching mailbox
        data_we            = 1'b1;
        full_nxt[hit_slot] = 1'b1;
        if (hit_ien_r) begin
          pend_nxt[ch_sel][hit_idx_r] = 1'b1;
          res.irq_raise               = 1'b1;
        end
        res.found_mailbox = 4'(hit_idx_r);
        emit              = 1'b1;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.pending_mask = ch_ok ? 16'(pend_nxt[ch_sel]) : '0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_done_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      filt_vld_r  <= '0;
      full_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      filt_vld_r  <= filt_vld_nxt;
      full_r      <= full_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= emit;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_ien_r <= hit_ien_nxt;
    if (start && !busy) begin
      item_r <= in_item;
      rid_r  <= can_maf_pkg::norm_id(in_item.extended, in_item.ident);
    end
    if (emit) begin
      out_item_r <= res;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  a_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.irq_raise |-> out_item.pending_mask[out_item.found_mailbox])
    else $error("interrupt raised without pending bit");

  a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == can_maf_pkg::ST_NOMATCH)
      |-> !out_item.irq_raise && (out_item.found_mailbox == '0))
    else $error("unmatched frame reported a mailbox");

endmodule
